// ===== design/rcea_pkg.sv =====
// Shared types and constants for the range count-equal-then-assign block.
`default_nettype none

package rcea_pkg;

   // Fixed field widths of the item and result ports, and of the step address.
   localparam int IDX_W  = 10;
   localparam int VAL_W  = 32;
   localparam int CNT_W  = 11;
   localparam int STEP_W = 3;

   // Opcodes of an input item.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Microprogram step addresses.
   localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DECODE = 3'd1;
   localparam logic [STEP_W-1:0] STEP_SETUP  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_WALK   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_RET    = 3'd5;
   localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd6;

   // Jump conditions: when true the sequencer goes to the target, else to the next step.
   typedef enum logic [2:0] {
      COND_NEXT     = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_NOT_ACC  = 3'd2,
      COND_IS_LOAD  = 3'd3,
      COND_EMPTY    = 3'd4,
      COND_NOT_LAST = 3'd5,
      COND_OUT_BUSY = 3'd6
   } cond_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic              req_ready;
      logic              decode;
      logic              first_read;
      logic              walk;
      logic              emit;
      logic              load_write;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   // Status flags from the datapath that the jump conditions test.
   typedef struct packed {
      logic accepted;
      logic is_load;
      logic empty;
      logic last;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

// ===== design/rcea_ctrl_rom.sv =====
// Read-only control store holding the microprogram.
`default_nettype none

module rcea_ctrl_rom (
   input  wire logic [rcea_pkg::STEP_W-1:0] step,
   output rcea_pkg::ctrl_word_type          cw
);

   // One control word per step; unused addresses return to fetch.
   always_comb begin
      cw = '0;
      case (step)
         rcea_pkg::STEP_FETCH: begin
            cw.req_ready = 1'b1;
            cw.cond      = rcea_pkg::COND_NOT_ACC;
            cw.target    = rcea_pkg::STEP_FETCH;
         end
         rcea_pkg::STEP_DECODE: begin
            cw.decode = 1'b1;
            cw.cond   = rcea_pkg::COND_IS_LOAD;
            cw.target = rcea_pkg::STEP_LOAD;
         end
         rcea_pkg::STEP_SETUP: begin
            cw.first_read = 1'b1;
            cw.cond       = rcea_pkg::COND_EMPTY;
            cw.target     = rcea_pkg::STEP_EMIT;
         end
         rcea_pkg::STEP_WALK: begin
            cw.walk   = 1'b1;
            cw.cond   = rcea_pkg::COND_NOT_LAST;
            cw.target = rcea_pkg::STEP_WALK;
         end
         rcea_pkg::STEP_EMIT: begin
            cw.emit   = 1'b1;
            cw.cond   = rcea_pkg::COND_OUT_BUSY;
            cw.target = rcea_pkg::STEP_EMIT;
         end
         rcea_pkg::STEP_RET: begin
            cw.cond   = rcea_pkg::COND_ALWAYS;
            cw.target = rcea_pkg::STEP_FETCH;
         end
         rcea_pkg::STEP_LOAD: begin
            cw.load_write = 1'b1;
            cw.cond       = rcea_pkg::COND_ALWAYS;
            cw.target     = rcea_pkg::STEP_FETCH;
         end
         default: begin
            cw.cond   = rcea_pkg::COND_ALWAYS;
            cw.target = rcea_pkg::STEP_FETCH;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/rcea_seq.sv =====
// Micro-sequencer: step counter with conditional jumps.
`default_nettype none

module rcea_seq (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rcea_pkg::ctrl_word_type      cw,
   input  wire rcea_pkg::status_type         status,
   output logic [rcea_pkg::STEP_W-1:0]       step
);

   logic [rcea_pkg::STEP_W-1:0] upc_ff;
   logic [rcea_pkg::STEP_W-1:0] upc_in;
   logic                        take;

   // Evaluate the jump condition of the current control word.
   always_comb begin
      case (cw.cond)
         rcea_pkg::COND_NEXT:     take = 1'b0;
         rcea_pkg::COND_ALWAYS:   take = 1'b1;
         rcea_pkg::COND_NOT_ACC:  take = !status.accepted;
         rcea_pkg::COND_IS_LOAD:  take = status.is_load;
         rcea_pkg::COND_EMPTY:    take = status.empty;
         rcea_pkg::COND_NOT_LAST: take = !status.last;
         rcea_pkg::COND_OUT_BUSY: take = status.out_busy;
         default:                 take = 1'b1;
      endcase
      upc_in = take ? cw.target : upc_ff + rcea_pkg::STEP_W'(1);
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= rcea_pkg::STEP_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign step = upc_ff;

endmodule

`default_nettype wire

// ===== design/rcea_dpath.sv =====
// Datapath: element memory, item registers, walk pointers, counter and result register.
`default_nettype none

module rcea_dpath #(
   parameter int DEPTH = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rcea_pkg::ctrl_word_type           cw,
   input  wire logic                              req_valid,
   input  wire logic                              req_opcode,
   input  wire logic [rcea_pkg::IDX_W-1:0]        req_left_index,
   input  wire logic [rcea_pkg::IDX_W-1:0]        req_right_index,
   input  wire logic signed [rcea_pkg::VAL_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [rcea_pkg::CNT_W-1:0]             rsp_match_count,
   output rcea_pkg::status_type                   status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [rcea_pkg::VAL_W-1:0] mem [DEPTH];
   logic [rcea_pkg::VAL_W-1:0] rd_data_ff;

   logic                       op_ff;
   logic [rcea_pkg::IDX_W-1:0] lo_ff;
   logic [rcea_pkg::IDX_W-1:0] hi_ff;
   logic [rcea_pkg::VAL_W-1:0] val_ff;
   logic [rcea_pkg::IDX_W-1:0] rd_ptr_ff;
   logic [rcea_pkg::IDX_W-1:0] pend_addr_ff;
   logic [rcea_pkg::CNT_W-1:0] cnt_ff;
   logic                       rsp_valid_ff;
   logic [rcea_pkg::CNT_W-1:0] rsp_match_count_ff;

   logic                       accepted;
   logic                       hi_over;
   logic [rcea_pkg::IDX_W-1:0] hi_clamp;
   logic                       lo_in_range;
   logic                       last;
   logic                       out_busy;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic                       match;

   // Decode of the latched item and walk progress.
   always_comb begin
      accepted    = req_valid && cw.req_ready;
      hi_over     = 32'(hi_ff) >= 32'(DEPTH);
      hi_clamp    = hi_over ? rcea_pkg::IDX_W'(DEPTH - 1) : hi_ff;
      lo_in_range = 32'(lo_ff) < 32'(DEPTH);
      last        = pend_addr_ff == hi_ff;
      out_busy    = rsp_valid_ff && !rsp_ready;
      match       = rd_data_ff == val_ff;
   end

   // Memory port selection: one read and one write per cycle, never the same address.
   always_comb begin
      rd_en   = cw.first_read || (cw.walk && !last);
      rd_addr = cw.first_read ? AW'(lo_ff) : AW'(rd_ptr_ff);
      wr_en   = cw.walk || (cw.load_write && lo_in_range);
      wr_addr = cw.walk ? AW'(pend_addr_ff) : AW'(lo_ff);
   end

   assign status.accepted = accepted;
   assign status.is_load  = op_ff == rcea_pkg::OP_LOAD;
   assign status.empty    = lo_ff > hi_ff;
   assign status.last     = last;
   assign status.out_busy = out_busy;

   // Element memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= val_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Item registers, walk pointers and match counter.
   always_ff @(posedge clock) begin
      if (accepted) begin
         op_ff  <= req_opcode;
         lo_ff  <= req_left_index;
         hi_ff  <= req_right_index;
         val_ff <= req_value;
      end
      if (cw.decode) begin
         hi_ff  <= hi_clamp;
         cnt_ff <= '0;
      end
      if (cw.first_read) begin
         pend_addr_ff <= lo_ff;
         rd_ptr_ff    <= lo_ff + rcea_pkg::IDX_W'(1);
      end
      if (cw.walk) begin
         if (match) begin
            cnt_ff <= cnt_ff + rcea_pkg::CNT_W'(1);
         end
         if (!last) begin
            pend_addr_ff <= rd_ptr_ff;
            rd_ptr_ff    <= rd_ptr_ff + rcea_pkg::IDX_W'(1);
         end
      end
   end

   // Result register: loaded when empty or being drained.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cw.emit && !out_busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cw.emit && !out_busy) begin
         rsp_match_count_ff <= cnt_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_count = rsp_match_count_ff;

   // The walk never runs past the clamped end of the range.
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cw.walk |-> (pend_addr_ff <= hi_ff && pend_addr_ff >= lo_ff))
      else $error("walk address outside the range");

   // The count can never exceed the number of elements already visited.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cw.walk |-> cnt_ff <= (rcea_pkg::CNT_W'(pend_addr_ff) - rcea_pkg::CNT_W'(lo_ff)))
      else $error("match count exceeds elements visited");

   // A read and a write in the same cycle never hit the same element.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> rd_addr != wr_addr)
      else $error("read and write to the same address");

   // A first read for a non-empty range is always followed by the walk.
   a_setup_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cw.first_read && !status.empty) |=> cw.walk)
      else $error("walk did not follow the first read");

endmodule

`default_nettype wire

// ===== design/range_count_equal_then_assign.sv =====
// Top level of the range count-equal-then-assign block.
//
// Keeps DEPTH signed 32-bit elements in an on-chip memory. Items arrive on
// the req_ channel (valid/ready). A load item writes one element and gives no
// result; a query item counts the elements of [left, right] equal to value,
// then writes value over that range, and gives one result on the rsp_ channel.
// A right index past the end is clamped; an empty range returns zero.
// Control is a seven-step microprogram; the walk step visits one element per
// cycle, reading the next element while writing the current one.
// A load goes through the decode and load steps before the next fetch. A query
// goes through decode, setup, one walk step per element, emit and return; an
// empty query skips the walk. The memory port pair sets the walk rate.
// Reset returns the sequencer to fetch and clears the result valid; memory
// contents are undefined until written. When the receiver stalls, the result
// is held in the output register and the next item can still be accepted and
// worked on; it waits at its emit step until the held result is taken.
`default_nettype none

module range_count_equal_then_assign #(
   parameter int DEPTH = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_opcode,
   input  wire logic [rcea_pkg::IDX_W-1:0]        req_left_index,
   input  wire logic [rcea_pkg::IDX_W-1:0]        req_right_index,
   input  wire logic signed [rcea_pkg::VAL_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [rcea_pkg::CNT_W-1:0]             rsp_match_count
);

   logic [rcea_pkg::STEP_W-1:0] step;
   rcea_pkg::ctrl_word_type     cw;
   rcea_pkg::status_type        status;

   // Control store.
   rcea_ctrl_rom u_rom (
      .step (step),
      .cw   (cw)
   );

   // Step counter and jump logic.
   rcea_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .cw     (cw),
      .status (status),
      .step   (step)
   );

   // Memory and arithmetic.
   rcea_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cw              (cw),
      .req_valid       (req_valid),
      .req_opcode      (req_opcode),
      .req_left_index  (req_left_index),
      .req_right_index (req_right_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match_count (rsp_match_count),
      .status          (status)
   );

   assign req_ready = cw.req_ready;

endmodule

`default_nettype wire

// ===== sim/tb_range_count_equal_then_assign.sv =====
// Self-checking testbench for the range count-equal-then-assign block.
`timescale 1ns / 100ps

module tb_range_count_equal_then_assign;

   localparam int STORE_DEPTH     = 1024;
   // Queries stay inside the first LIVE_DEPTH elements, which are all loaded first.
   localparam int LIVE_DEPTH      = 256;
   localparam int POOL_SIZE       = 6;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT  = 12000;
   localparam int PRINT_LIMIT     = 200;

   // Clock, reset and block ports; the driven inputs are known from time zero.
   logic                              clock           = 1'b0;
   logic                              reset           = 1'b1;
   logic                              req_valid       = 1'b0;
   logic                              req_ready;
   logic                              req_opcode      = rcea_pkg::OP_LOAD;
   logic [rcea_pkg::IDX_W-1:0]        req_left_index  = '0;
   logic [rcea_pkg::IDX_W-1:0]        req_right_index = '0;
   logic signed [rcea_pkg::VAL_W-1:0] req_value       = '0;
   logic                              rsp_valid;
   logic                              rsp_ready       = 1'b0;
   logic [rcea_pkg::CNT_W-1:0]        rsp_match_count;

   // Copy of the element array and the counts still owed by the block.
   logic signed [rcea_pkg::VAL_W-1:0] element_copy [STORE_DEPTH];
   logic [rcea_pkg::CNT_W-1:0]        pending_match_counts [$];
   logic [rcea_pkg::CNT_W-1:0]        oldest_count;
   logic signed [rcea_pkg::VAL_W-1:0] value_pool [POOL_SIZE];

   int error_count      = 0;
   int quiet_cycles     = 0;
   bit idling_on        = 1'b1;
   bit hold_off_request = 1'b0;

   range_count_equal_then_assign #(
      .DEPTH(STORE_DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_left_index (req_left_index),
      .req_right_index(req_right_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_match_count(rsp_match_count)
   );

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Prints one line per mismatch, up to a limit, and counts every one.
   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Applies one accepted item to the element copy and, for a query, queues its count.
   function automatic void predict_match_count(input logic op,
                                                input logic [rcea_pkg::IDX_W-1:0] first_idx,
                                                input logic [rcea_pkg::IDX_W-1:0] last_idx,
                                                input logic signed [rcea_pkg::VAL_W-1:0] val);
      int idx;
      int stop_idx;
      int hit_total;
      if (op == rcea_pkg::OP_LOAD) begin
         if (first_idx < STORE_DEPTH)
            element_copy[first_idx] = val;
      end else begin
         // A right index past the end is clamped; an empty range counts nothing.
         stop_idx  = (last_idx >= STORE_DEPTH) ? STORE_DEPTH - 1 : int'(last_idx);
         hit_total = 0;
         for (idx = first_idx; idx <= stop_idx; idx++) begin
            if (element_copy[rcea_pkg::IDX_W'(idx)] == val)
               hit_total++;
            element_copy[rcea_pkg::IDX_W'(idx)] = val;
         end
         pending_match_counts = {pending_match_counts, rcea_pkg::CNT_W'(hit_total)};
      end
   endfunction

   // Mostly values from a small pool so that matches are common.
   function automatic logic signed [rcea_pkg::VAL_W-1:0] pick_value();
      if ($urandom_range(0, 3) == 0)
         return $urandom;
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Offers one item, waits for its acceptance and updates the prediction.
   // Valid stays high after acceptance unless a gap follows.
   task automatic send_item(input logic op, input int first_idx, input int last_idx,
                            input logic signed [rcea_pkg::VAL_W-1:0] val);
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_left_index  <= rcea_pkg::IDX_W'(first_idx);
      req_right_index <= rcea_pkg::IDX_W'(last_idx);
      req_value       <= val;
      do @(posedge clock); while (!req_ready);
      predict_match_count(op, rcea_pkg::IDX_W'(first_idx), rcea_pkg::IDX_W'(last_idx), val);
   endtask

   // Drops valid and waits until every owed count has arrived.
   task automatic wait_for_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_match_counts.size() != 0);
   endtask

   // One random item: loads, short ranges, empty ranges and a few wide ones.
   task automatic send_random_item(input int max_len);
      int roll;
      int len;
      int first_idx;
      int last_idx;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         send_item(rcea_pkg::OP_LOAD, $urandom, $urandom, pick_value());
      end else if (roll < 36) begin
         first_idx = $urandom_range(1, STORE_DEPTH - 1);
         last_idx  = $urandom_range(0, first_idx - 1);
         send_item(rcea_pkg::OP_QUERY, first_idx, last_idx, pick_value());
      end else if (roll < 38) begin
         first_idx = $urandom_range(0, LIVE_DEPTH - 1);
         last_idx  = $urandom_range(first_idx, LIVE_DEPTH - 1);
         send_item(rcea_pkg::OP_QUERY, first_idx, last_idx, pick_value());
      end else begin
         len       = $urandom_range(1, max_len);
         first_idx = $urandom_range(0, LIVE_DEPTH - len);
         last_idx  = first_idx + len - 1;
         send_item(rcea_pkg::OP_QUERY, first_idx, last_idx, pick_value());
      end
   endtask

   // Writes every element of the live window once so that no query reads an unwritten entry.
   task automatic test_fill_store;
      int idx;
      value_pool[0] = 32'sd0;
      value_pool[1] = -32'sd1;
      value_pool[2] = 32'sh8000_0000;
      value_pool[3] = 32'sh7FFF_FFFF;
      value_pool[4] = $urandom;
      value_pool[5] = $urandom;
      for (idx = 0; idx < LIVE_DEPTH; idx++)
         send_item(rcea_pkg::OP_LOAD, idx, $urandom, pick_value());
   endtask

   // Field extremes, full and single-element ranges, and empty ranges.
   task automatic test_directed_cases;
      send_item(rcea_pkg::OP_QUERY, 0, LIVE_DEPTH - 1, 32'sd0);
      send_item(rcea_pkg::OP_QUERY, 0, LIVE_DEPTH - 1, 32'sd0);
      send_item(rcea_pkg::OP_QUERY, 0, LIVE_DEPTH - 1, 32'sh8000_0000);
      send_item(rcea_pkg::OP_LOAD, 0, STORE_DEPTH - 1, 32'sh7FFF_FFFF);
      send_item(rcea_pkg::OP_LOAD, LIVE_DEPTH - 1, 0, 32'sd0);
      send_item(rcea_pkg::OP_QUERY, 0, 0, 32'sh7FFF_FFFF);
      send_item(rcea_pkg::OP_QUERY, LIVE_DEPTH - 1, LIVE_DEPTH - 1, 32'sd0);
      send_item(rcea_pkg::OP_QUERY, LIVE_DEPTH - 2, LIVE_DEPTH - 1, 32'sh8000_0000);
      // Empty ranges must return zero and leave the store alone.
      send_item(rcea_pkg::OP_QUERY, 10, 9, -32'sd1);
      send_item(rcea_pkg::OP_QUERY, STORE_DEPTH - 1, 0, -32'sd1);
      send_item(rcea_pkg::OP_QUERY, 5, 5, -32'sd1);
      send_item(rcea_pkg::OP_QUERY, 5, 5, -32'sd1);
      send_item(rcea_pkg::OP_QUERY, 128, LIVE_DEPTH - 1, -32'sd1);
      send_item(rcea_pkg::OP_LOAD, 200, 3, value_pool[4]);
      send_item(rcea_pkg::OP_QUERY, 190, 210, value_pool[4]);
      send_item(rcea_pkg::OP_QUERY, 0, LIVE_DEPTH - 1, value_pool[5]);
   endtask

   // Random mix of loads and queries with idling on both sides.
   task automatic test_random_mix(input int item_total);
      repeat (item_total) send_random_item(32);
   endtask

   // The receiver holds off for a long stretch while short queries keep coming.
   task automatic test_output_backpressure;
      wait_for_results();
      hold_off_request = 1'b1;
      repeat (12) send_item(rcea_pkg::OP_QUERY, 100, 100 + $urandom_range(0, 7), pick_value());
   endtask

   // The sender stops until the block has delivered every owed count.
   task automatic test_sender_pause;
      test_random_mix(40);
      wait_for_results();
      test_random_mix(40);
   endtask

   // Final stretch without idling on either side.
   task automatic test_back_to_back;
      idling_on = 1'b0;
      repeat (100) send_random_item(16);
   endtask

   // Result receiver: random stall bursts, one long hold-off on request.
   initial begin : receiver
      int burst;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (burst - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compares each accepted result with the oldest owed count.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_match_counts.size() == 0) begin
            report_mismatch($sformatf("count %0d arrived with no query outstanding",
                                      rsp_match_count));
         end else begin
            oldest_count = pending_match_counts.pop_front();
            if (rsp_match_count !== oldest_count)
               report_mismatch($sformatf("match_count %0d, expected %0d",
                                         rsp_match_count, oldest_count));
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_fill_store();
      test_directed_cases();
      test_random_mix(220);
      test_output_backpressure();
      test_sender_pause();
      test_random_mix(60);
      test_back_to_back();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
